// ===== design/drt_pkg.sv =====
package drt_pkg;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int CTRL_W   = 3;
  localparam int CPHASE_W = 10;

  // item kinds
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

  // register offsets
  localparam logic [ADDR_W-1:0] ADDR_DIV  = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_CNT  = 3'd1;
  localparam logic [ADDR_W-1:0] ADDR_MOD  = 3'd2;
  localparam logic [ADDR_W-1:0] ADDR_CTRL = 3'd3;

  localparam int CTRL_EN_BIT = 2;

  // counter periods in ticks, by control select code
  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   reg_addr;
    logic [BYTE_W-1:0]   write_data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              timer_irq;
    logic              bad_address;
  } result_t;

  // handshake between the input stage and the result stage
  typedef struct packed {
    logic take;   // item moves on this cycle
  } stage_ctl_t;

  // last phase value before the counter steps
  function automatic logic [CPHASE_W-1:0] period_last(input logic [1:0] sel);
    logic [CPHASE_W-1:0] last;
    unique case (sel)
      SEL_1024: last = CPHASE_W'(1024 - 1);
      SEL_16:   last = CPHASE_W'(16 - 1);
      SEL_64:   last = CPHASE_W'(64 - 1);
      SEL_256:  last = CPHASE_W'(256 - 1);
      default:  last = CPHASE_W'(1024 - 1);
    endcase
    return last;
  endfunction

endpackage

// ===== design/drt_in_reg.sv =====
module drt_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  drt_pkg::item_t     item_in,
  input  logic               down_free,
  output drt_pkg::stage_ctl_t ctl,
  output drt_pkg::item_t     item_q
);

  logic full;
  logic take;
  logic load;

  assign take     = full && down_free;
  assign in_stall = full && !down_free;
  assign load     = in_valid && !in_stall;

  assign ctl.take = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= item_in;
    end
  end

endmodule

// ===== design/drt_core.sv =====
module drt_core #(
  parameter int DIVIDER_PERIOD = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  drt_pkg::stage_ctl_t ctl,
  input  drt_pkg::item_t      item,
  output drt_pkg::result_t    result
);

  localparam int DPHASE_W = (DIVIDER_PERIOD > 2) ? $clog2(DIVIDER_PERIOD) : 1;
  localparam logic [DPHASE_W-1:0] DPHASE_LAST = DPHASE_W'(DIVIDER_PERIOD - 1);

  logic [drt_pkg::BYTE_W-1:0]   div_value, div_value_next;
  logic [DPHASE_W-1:0]          div_phase, div_phase_next;
  logic [drt_pkg::BYTE_W-1:0]   cnt_value, cnt_value_next;
  logic [drt_pkg::BYTE_W-1:0]   mod_value, mod_value_next;
  logic [drt_pkg::CTRL_W-1:0]   ctrl, ctrl_next;
  logic [drt_pkg::CPHASE_W-1:0] cnt_phase, cnt_phase_next;
  logic                         is_access;
  logic                         bad;

  assign is_access = (item.action == drt_pkg::ACT_READ) || (item.action == drt_pkg::ACT_WRITE);
  assign bad       = item.reg_addr[drt_pkg::ADDR_W-1];

  always_comb begin
    div_value_next     = div_value;
    div_phase_next     = div_phase;
    cnt_value_next     = cnt_value;
    mod_value_next     = mod_value;
    ctrl_next          = ctrl;
    cnt_phase_next     = cnt_phase;
    result.read_data   = '0;
    result.timer_irq   = 1'b0;
    result.bad_address = is_access && bad;

    if (item.action == drt_pkg::ACT_TICK) begin
      // divider runs free
      if (div_phase == DPHASE_LAST) begin
        div_phase_next = '0;
        div_value_next = div_value + 8'd1;
      end else begin
        div_phase_next = div_phase + DPHASE_W'(1);
      end
      // counter steps only while enabled
      if (ctrl[drt_pkg::CTRL_EN_BIT]) begin
        if (cnt_phase == drt_pkg::period_last(ctrl[1:0])) begin
          cnt_phase_next = '0;
          if (cnt_value == 8'hFF) begin
            cnt_value_next   = mod_value;
            result.timer_irq = 1'b1;
          end else begin
            cnt_value_next = cnt_value + 8'd1;
          end
        end else begin
          cnt_phase_next = cnt_phase + drt_pkg::CPHASE_W'(1);
        end
      end
    end else if (is_access && !bad) begin
      if (item.action == drt_pkg::ACT_READ) begin
        unique case (item.reg_addr)
          drt_pkg::ADDR_DIV:  result.read_data = div_value;
          drt_pkg::ADDR_CNT:  result.read_data = cnt_value;
          drt_pkg::ADDR_MOD:  result.read_data = mod_value;
          drt_pkg::ADDR_CTRL: result.read_data = {5'd0, ctrl};
          default:            result.read_data = '0;
        endcase
      end else begin
        unique case (item.reg_addr)
          drt_pkg::ADDR_DIV: div_value_next = '0;
          drt_pkg::ADDR_CNT: cnt_value_next = item.write_data;
          drt_pkg::ADDR_MOD: mod_value_next = item.write_data;
          drt_pkg::ADDR_CTRL: begin
            ctrl_next      = item.write_data[drt_pkg::CTRL_W-1:0];
            cnt_phase_next = '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_value <= '0;
      div_phase <= '0;
      cnt_value <= '0;
      mod_value <= '0;
      ctrl      <= '0;
      cnt_phase <= '0;
    end else if (ctl.take) begin
      div_value <= div_value_next;
      div_phase <= div_phase_next;
      cnt_value <= cnt_value_next;
      mod_value <= mod_value_next;
      ctrl      <= ctrl_next;
      cnt_phase <= cnt_phase_next;
    end
  end

endmodule

// ===== design/drt_out_reg.sv =====
module drt_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  drt_pkg::stage_ctl_t ctl,
  input  drt_pkg::result_t    result_in,
  output logic                down_free,
  output logic                out_valid,
  input  logic                out_stall,
  output drt_pkg::result_t    result_q
);

  logic full;

  assign down_free = !full || !out_stall;
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (ctl.take) begin
      full <= 1'b1;
    end else if (!out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      result_q <= result_in;
    end
  end

endmodule

// ===== design/divider_and_reload_timer_top.sv =====
// Path: an item passes the input register, then the result register; the
//   register update lands with the result.
// Throughput: one item per cycle, set by the single-pass update between the
//   two registers; stalls on the result side back up through the input stage.
// Reset: synchronous, active high; clears divider, counter, modulo, control
//   and both phase counters, and empties both stages.
module divider_and_reload_timer_top #(
  parameter int DIVIDER_PERIOD = 256
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [2:0] reg_addr,
  input  logic [7:0] write_data,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       timer_irq,
  output logic       bad_address
);

  drt_pkg::item_t      item_in;
  drt_pkg::item_t      item_q;
  drt_pkg::stage_ctl_t ctl;
  drt_pkg::result_t    result_comb;
  drt_pkg::result_t    result_q;
  logic                down_free;

  // Gather the input fields into one item.
  assign item_in.action     = action;
  assign item_in.reg_addr   = reg_addr;
  assign item_in.write_data = write_data;

  // Input register: hold one item while the result side is stalled, so a
  // new transfer is taken whenever the result register can move on.
  drt_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .item_in   (item_in),
    .down_free (down_free),
    .ctl       (ctl),
    .item_q    (item_q)
  );

  // Timer state and the single-pass update: advance the divider, and the counter
  // while enabled, on a tick; serve reads and writes to valid addresses otherwise.
  drt_core #(
    .DIVIDER_PERIOD (DIVIDER_PERIOD)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item_q),
    .result (result_comb)
  );

  // Result register: hold the finished result until the transfer completes.
  drt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .result_in (result_comb),
    .down_free (down_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_q  (result_q)
  );

  assign read_data   = result_q.read_data;
  assign timer_irq   = result_q.timer_irq;
  assign bad_address = result_q.bad_address;

endmodule

// ===== design/drt_checker.sv =====
module drt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] action,
  input logic [2:0] reg_addr,
  input logic [7:0] write_data,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic       timer_irq,
  input logic       bad_address
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(timer_irq)
      && $stable(bad_address))
    else $error("stalled result changed");

  // an interrupt comes only from a tick
  a_irq_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && timer_irq |-> !bad_address && (read_data == 8'd0))
    else $error("interrupt on a register access");

  // a bad access returns nothing
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_address |-> read_data == 8'd0)
    else $error("bad address returned data");

  // input side free while no result waits
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result stage");

  // result stage empty after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind divider_and_reload_timer_top drt_checker u_drt_checker (.*);
